// File: sv/tdsu_pkg.sv
package tdsu_pkg;

  // Command codes
  localparam logic [2:0] CMD_PUSH = 3'd0;
  localparam logic [2:0] CMD_DROP = 3'd1;
  localparam logic [2:0] CMD_DUP  = 3'd2;
  localparam logic [2:0] CMD_MUL  = 3'd3;
  localparam logic [2:0] CMD_EMIT = 3'd4;

  // Entry type codes
  localparam logic [1:0] TY_INT = 2'd0;
  localparam logic [1:0] TY_FLT = 2'd1;
  localparam logic [1:0] TY_STR = 2'd2;
  localparam logic [1:0] TY_BAD = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNDER = 2'd1;
  localparam logic [1:0] ST_OVER  = 2'd2;
  localparam logic [1:0] ST_TYPE  = 2'd3;

  localparam logic [31:0] QNAN = 32'h7FC0_0000;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [1:0]  push_type;
    logic [31:0] push_value;
  } cmd_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        out_valid;
    logic [1:0]  out_type;
    logic [31:0] out_value;
    logic [7:0]  depth;
  } res_t;

endpackage

// File: sv/tdsu_cmd_if.sv
interface tdsu_cmd_if import tdsu_pkg::*; ();
  logic     valid;
  logic     ready;
  cmd_req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: sv/tdsu_res_if.sv
interface tdsu_res_if import tdsu_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: sv/typed_data_stack_unit.sv
// Typed data stack: each request carries one command (push, drop, dup, multiply, pop and
// emit) and yields exactly one result request with status and the new depth. Entries live
// in a STACK_DEPTH x 34 synchronous memory (one write port, two registered read ports);
// no clearing pass follows reset. Push, drop, errors and unknown commands finish at
// acceptance; dup, emit and a string-operand multiply finish in an execute state, an
// integer multiply goes on through the shared 32x32 multiplier, and a float multiply also
// passes the five-step normaliser, the operand rounding and the three-stage result rounding.
// A new request is taken once the previous command has finished and its result has left
// the output register or is leaving it in the same cycle; a stalled result holds off both
// the finishing command and the input.
module typed_data_stack_unit import tdsu_pkg::*; #(
  parameter int STACK_DEPTH = 128
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  tdsu_cmd_if.sink      cmd_i,
  tdsu_res_if.source    res_o
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_EXEC = 4'd1;
  localparam logic [3:0] S_NORM = 4'd2;
  localparam logic [3:0] S_RND  = 4'd3;
  localparam logic [3:0] S_MUL  = 4'd4;
  localparam logic [3:0] S_FN1  = 4'd5;
  localparam logic [3:0] S_FN2  = 4'd6;
  localparam logic [3:0] S_FN3  = 4'd7;
  localparam logic [3:0] S_WB   = 4'd8;

  typedef struct packed {
    logic [1:0]  ty;
    logic [31:0] val;
  } entry_t;

  typedef struct packed {
    logic               sign;
    logic signed [9:0]  e;
    logic [31:0]        m;
  } lane_t;

  // Unpack an operand into sign, exponent and mantissa (float mantissas left-aligned, int magnitudes as they are)
  function automatic lane_t lane_in(entry_t x);
    lane_t l;
    l.sign = x.val[31];
    if (x.ty == TY_FLT) begin
      if (x.val[30:23] == 8'd0) begin
        l.e = -10'sd126;
        l.m = {1'b0, x.val[22:0], 8'd0};
      end else begin
        l.e = 10'($signed({2'b00, x.val[30:23]})) - 10'sd127;
        l.m = {1'b1, x.val[22:0], 8'd0};
      end
    end else begin
      l.e = 10'sd31;
      l.m = x.val[31] ? (~x.val + 32'd1) : x.val;
    end
    return l;
  endfunction

  // One step of the leading-zero shift: 16, 8, 4, 2, 1
  function automatic lane_t norm_step(lane_t l, logic [2:0] step);
    lane_t r;
    r = l;
    case (step)
      3'd0: if (l.m[31:16] == '0) begin r.m = l.m << 16; r.e = l.e - 10'sd16; end
      3'd1: if (l.m[31:24] == '0) begin r.m = l.m << 8;  r.e = l.e - 10'sd8;  end
      3'd2: if (l.m[31:28] == '0) begin r.m = l.m << 4;  r.e = l.e - 10'sd4;  end
      3'd3: if (l.m[31:30] == '0) begin r.m = l.m << 2;  r.e = l.e - 10'sd2;  end
      3'd4: if (!l.m[31])         begin r.m = l.m << 1;  r.e = l.e - 10'sd1;  end
      default: r = l;
    endcase
    return r;
  endfunction

  // Round the 32-bit mantissa to 24 bits, nearest even
  function automatic lane_t lane_rnd(lane_t l);
    lane_t       r;
    logic        inc;
    logic [24:0] s;
    inc = l.m[7] & ((|l.m[6:0]) | l.m[8]);
    s   = {1'b0, l.m[31:8]} + 25'(inc);
    r   = l;
    if (s[24]) begin
      r.m = {8'd0, 24'h80_0000};
      r.e = l.e + 10'sd1;
    end else begin
      r.m = {8'd0, s[23:0]};
    end
    return r;
  endfunction

  // Stack memory
  entry_t mem [STACK_DEPTH];
  entry_t rd0_q, rd1_q;

  logic          we;
  logic [AW-1:0] wa;
  entry_t        wd;

  logic [3:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] cm1, cm2;
  logic [2:0]    cmd_q;

  // Output register
  logic res_valid_q;
  res_t res_q, res_d;
  logic res_ld;
  logic fin;
  logic acc;

  // Multiply datapath
  lane_t              lane_q [2];
  logic               int_q, sgn_q, nan_q, inf_q, zero_q;
  logic [2:0]         step_q;
  logic [63:0]        prod_q;
  logic [47:0]        sig_q;
  logic signed [10:0] be_q;
  logic [4:0]         sh_q;
  logic               sub_q;
  logic [23:0]        keep_q;
  logic               g_q, st_q;
  logic [31:0]        fres_q;

  entry_t a_ent, b_ent;
  logic   a_str, b_str;
  logic [1:0] ptype;

  assign cm1   = count_q - CW'(1);
  assign cm2   = count_q - CW'(2);
  assign a_ent = rd0_q;
  assign b_ent = rd1_q;
  assign a_str = (a_ent.ty == TY_STR);
  assign b_str = (b_ent.ty == TY_STR);
  assign ptype = (cmd_i.data.push_type == TY_BAD) ? TY_STR : cmd_i.data.push_type;

  assign fin           = !res_valid_q || res_o.ready;
  assign cmd_i.ready   = (state_q == S_IDLE) && fin;
  assign acc           = cmd_i.valid && cmd_i.ready;
  assign res_o.valid   = res_valid_q;
  assign res_o.data    = res_q;

  // Memory: one write, two registered reads
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd0_q <= mem[cm1[AW-1:0]];
    rd1_q <= mem[cm2[AW-1:0]];
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    we      = 1'b0;
    wa      = '0;
    wd      = '0;
    res_ld  = 1'b0;
    res_d   = '0;
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          case (cmd_i.data.cmd)
            CMD_PUSH: begin
              res_ld = 1'b1;
              if (count_q >= FULL) begin
                res_d.status = ST_OVER;
              end else begin
                we      = 1'b1;
                wa      = count_q[AW-1:0];
                wd      = '{ty: ptype, val: cmd_i.data.push_value};
                count_d = count_q + CW'(1);
              end
            end
            CMD_DROP: begin
              res_ld = 1'b1;
              if (count_q == '0) res_d.status = ST_UNDER;
              else count_d = cm1;
            end
            CMD_DUP: begin
              if (count_q == '0) begin
                res_ld = 1'b1; res_d.status = ST_UNDER;
              end else if (count_q >= FULL) begin
                res_ld = 1'b1; res_d.status = ST_OVER;
              end else begin
                state_d = S_EXEC;
              end
            end
            CMD_MUL: begin
              if (count_q < CW'(2)) begin
                res_ld = 1'b1; res_d.status = ST_UNDER;
              end else begin
                state_d = S_EXEC;
              end
            end
            CMD_EMIT: begin
              if (count_q == '0) begin
                res_ld = 1'b1; res_d.status = ST_UNDER;
              end else begin
                state_d = S_EXEC;
              end
            end
            default: res_ld = 1'b1;
          endcase
        end
      end
      S_EXEC: begin
        case (cmd_q)
          CMD_DUP: begin
            if (fin) begin
              we      = 1'b1;
              wa      = count_q[AW-1:0];
              wd      = a_ent;
              count_d = count_q + CW'(1);
              res_ld  = 1'b1;
              state_d = S_IDLE;
            end
          end
          CMD_EMIT: begin
            if (fin) begin
              count_d         = cm1;
              res_ld          = 1'b1;
              res_d.out_valid = 1'b1;
              res_d.out_type  = a_ent.ty;
              res_d.out_value = a_ent.val;
              state_d         = S_IDLE;
            end
          end
          CMD_MUL: begin
            if (a_str || b_str) begin
              if (fin) begin
                count_d      = cm2;
                res_ld       = 1'b1;
                res_d.status = ST_TYPE;
                state_d      = S_IDLE;
              end
            end else if (a_ent.ty == TY_INT && b_ent.ty == TY_INT) begin
              state_d = S_MUL;
            end else begin
              state_d = S_NORM;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_NORM:  if (step_q == 3'd4) state_d = S_RND;
      S_RND:   state_d = S_MUL;
      S_MUL:   state_d = int_q ? S_WB : S_FN1;
      S_FN1:   state_d = S_FN2;
      S_FN2:   state_d = S_FN3;
      S_FN3:   state_d = S_WB;
      S_WB: begin
        if (fin) begin
          we      = 1'b1;
          wa      = cm2[AW-1:0];
          if (int_q) wd = '{ty: TY_INT, val: prod_q[31:0]};
          else wd = '{ty: TY_FLT, val: fres_q};
          count_d = cm1;
          res_ld  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    res_d.depth = 8'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      res_valid_q <= res_ld || (res_valid_q && !res_o.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ld) res_q <= res_d;
    if (acc) cmd_q <= cmd_i.data.cmd;
  end

  // Multiply datapath
  always_ff @(posedge clk_i) begin : mul_dp
    logic               an, bn, ai, bi, az, bz;
    logic [47:0]        psig;
    logic signed [10:0] be;
    logic signed [10:0] amt;
    logic [47:0]        mask;
    logic [47:0]        shd;
    logic [24:0]        r;
    logic signed [10:0] e2;
    logic [31:0]        bits;
    an   = 1'b0; bn = 1'b0; ai = 1'b0; bi = 1'b0; az = 1'b0; bz = 1'b0;
    psig = '0; be = '0; amt = '0; mask = '0; shd = '0; r = '0; e2 = '0; bits = '0;
    case (state_q)
      S_EXEC: begin
        step_q <= 3'd0;
        int_q  <= (a_ent.ty == TY_INT) && (b_ent.ty == TY_INT);
        sgn_q  <= a_ent.val[31] ^ b_ent.val[31];
        if (a_ent.ty == TY_FLT) begin
          an = (a_ent.val[30:23] == 8'hFF) && (a_ent.val[22:0] != '0);
          ai = (a_ent.val[30:23] == 8'hFF) && (a_ent.val[22:0] == '0);
          az = (a_ent.val[30:0] == '0);
        end else begin
          az = (a_ent.val == '0);
        end
        if (b_ent.ty == TY_FLT) begin
          bn = (b_ent.val[30:23] == 8'hFF) && (b_ent.val[22:0] != '0);
          bi = (b_ent.val[30:23] == 8'hFF) && (b_ent.val[22:0] == '0);
          bz = (b_ent.val[30:0] == '0);
        end else begin
          bz = (b_ent.val == '0);
        end
        // int operands carry no float sign on zero
        if (a_ent.ty == TY_INT && b_ent.ty == TY_INT) begin
          lane_q[0].m <= a_ent.val;
          lane_q[1].m <= b_ent.val;
        end else begin
          lane_q[0] <= lane_in(a_ent);
          lane_q[1] <= lane_in(b_ent);
        end
        nan_q  <= an || bn || (ai && bz) || (az && bi);
        inf_q  <= ai || bi;
        zero_q <= az || bz;
      end
      S_NORM: begin
        lane_q[0] <= norm_step(lane_q[0], step_q);
        lane_q[1] <= norm_step(lane_q[1], step_q);
        step_q    <= step_q + 3'd1;
      end
      S_RND: begin
        lane_q[0] <= lane_rnd(lane_q[0]);
        lane_q[1] <= lane_rnd(lane_q[1]);
      end
      S_MUL: begin
        prod_q <= 64'(lane_q[0].m) * 64'(lane_q[1].m);
      end
      S_FN1: begin
        // align the product so its leading one sits at bit 47
        psig = prod_q[47] ? prod_q[47:0] : {prod_q[46:0], 1'b0};
        be   = 11'(lane_q[0].e) + 11'(lane_q[1].e) + 11'sd127 + 11'($signed({1'b0, prod_q[47]}));
        sig_q <= psig;
        be_q  <= be;
        sub_q <= (be < 11'sd1);
        amt   = 11'sd1 - be;
        if (be >= 11'sd1) sh_q <= 5'd0;
        else if (amt > 11'sd31) sh_q <= 5'd31;
        else sh_q <= amt[4:0];
      end
      S_FN2: begin
        // denormalising shift with sticky collection
        mask   = (48'd1 << sh_q) - 48'd1;
        shd    = sig_q >> sh_q;
        keep_q <= shd[47:24];
        g_q    <= shd[23];
        st_q   <= (|shd[22:0]) || (|(sig_q & mask));
      end
      S_FN3: begin
        r = {1'b0, keep_q} + 25'(g_q & (st_q | keep_q[0]));
        if (sub_q) begin
          bits = {sgn_q, 7'd0, r[23], r[22:0]};
        end else begin
          e2 = be_q + 11'($signed({1'b0, r[24]}));
          if (e2 >= 11'sd255) bits = {sgn_q, 8'hFF, 23'd0};
          else bits = {sgn_q, e2[7:0], (r[24] ? 23'd0 : r[22:0])};
        end
        if (nan_q)       fres_q <= QNAN;
        else if (inf_q)  fres_q <= {sgn_q, 8'hFF, 23'd0};
        else if (zero_q) fres_q <= {sgn_q, 31'd0};
        else             fres_q <= bits;
      end
      default: ;
    endcase
  end

  // Checks
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL)
    else $error("stack count beyond depth");

  a_write_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> ({1'b0, wa} < (AW+1)'(STACK_DEPTH)))
    else $error("write outside stack memory");

  a_under_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_ld && res_d.status == ST_UNDER) |-> (count_d == count_q && !we))
    else $error("underflow changed the stack");

  a_emit_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.data.out_valid) |-> (res_o.data.status == ST_OK))
    else $error("emitted entry with error status");

  a_busy_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !cmd_i.ready)
    else $error("request taken while a command is in flight");

endmodule
